FILE: src/wrs_pkg.sv
// ----------------------------------------------------------------------------
// wrs_pkg: shared types and constants for the word replace stream filter
// Character and length widths, register indexes, separator decode, the
// command format passed from the front end to the back end.
// ----------------------------------------------------------------------------
package wrs_pkg;

    localparam int CHAR_W         = 8;
    localparam int LEN_W          = 4;
    localparam int WORD_W         = 64;
    localparam int BYTE_IDX_W     = 3;
    localparam int CFG_IDX_W      = 8;
    localparam int MAX_WORD_DEF   = 8;
    localparam int FIFO_DEPTH_DEF = 2;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FIND_WORD    = 8'd0,
        REG_FIND_LEN     = 8'd1,
        REG_REPLACE_WORD = 8'd2,
        REG_REPLACE_LEN  = 8'd3
    } cfg_reg_t;

    // word separators
    localparam logic [CHAR_W-1:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [CHAR_W-1:0] CH_SPACE      = 8'h20;
    localparam logic [CHAR_W-1:0] CH_COMMA      = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_PERIOD     = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_LESS       = 8'h3C;
    localparam logic [CHAR_W-1:0] CH_GREATER    = 8'h3E;
    localparam logic [CHAR_W-1:0] CH_LPAREN     = 8'h28;
    localparam logic [CHAR_W-1:0] CH_RPAREN     = 8'h29;
    localparam logic [CHAR_W-1:0] CH_QUOTE      = 8'h22;
    localparam logic [CHAR_W-1:0] CH_NUL        = 8'h00;

    typedef struct packed {
        logic [WORD_W-1:0] find_word;
        logic [LEN_W-1:0]  find_len;
        logic [WORD_W-1:0] replace_word;
        logic [LEN_W-1:0]  replace_len;
    } cfg_t;

    // one request for the back end: a prefix of a word, then one tail result
    typedef struct packed {
        logic              use_repl;
        logic [LEN_W-1:0]  pre_len;
        logic [CHAR_W-1:0] tail_char;
        logic              tail_le;
    } cmd_t;

    function automatic logic is_sep(input logic [CHAR_W-1:0] c);
        logic r;
        unique case (c) inside
            CH_UNDERSCORE, CH_SPACE, CH_COMMA, CH_PERIOD, CH_LESS,
            CH_GREATER, CH_LPAREN, CH_RPAREN, CH_QUOTE: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] n,
                                                   input logic [LEN_W-1:0] lim);
        return (n > lim) ? lim : n;
    endfunction

    function automatic logic [CHAR_W-1:0] byte_of(input logic [WORD_W-1:0] w,
                                                  input logic [BYTE_IDX_W-1:0] i);
        return w[CHAR_W*i +: CHAR_W];
    endfunction

endpackage

FILE: src/wrs_if.sv
// ----------------------------------------------------------------------------
// wrs interfaces: valid/ready channels of the word replace stream filter
// Text input channel, result output channel and configuration write channel.
// ----------------------------------------------------------------------------
interface wrs_text_if;
    logic                      valid;
    logic                      ready;
    logic [wrs_pkg::CHAR_W-1:0] char_in;
    logic                      line_end;

    modport source (output valid, output char_in, output line_end, input ready);
    modport sink   (input valid, input char_in, input line_end, output ready);
endinterface

interface wrs_result_if;
    logic                      valid;
    logic                      ready;
    logic [wrs_pkg::CHAR_W-1:0] char_out;
    logic                      line_end_out;
    logic                      last;

    modport source (output valid, output char_out, output line_end_out,
                    output last, input ready);
    modport sink   (input valid, input char_out, input line_end_out,
                    input last, output ready);
endinterface

interface wrs_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [wrs_pkg::CFG_IDX_W-1:0] index;
    logic [wrs_pkg::WORD_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: src/wrs_front.sv
// ----------------------------------------------------------------------------
// wrs_front: input classification and word match tracking
// Holds the configuration registers, tracks how many characters of the
// current word match the search word, and issues output requests.
// ----------------------------------------------------------------------------
module wrs_front #(
    parameter int MAX_WORD = wrs_pkg::MAX_WORD_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    wrs_text_if.sink             text,
    wrs_cfg_if.sink              cfg,
    input  logic                 push_ready,
    output logic                 push_valid,
    output wrs_pkg::cmd_t        push_data,
    output wrs_pkg::cfg_t        cfg_regs
);

    wrs_pkg::cfg_t                 cfg_reg;
    logic [wrs_pkg::LEN_W-1:0]     held_reg, held_next;
    logic                          pass_reg, pass_next;
    logic [wrs_pkg::LEN_W-1:0]     flen, rlen;
    logic                          accept;
    logic                          fin_repl;
    logic [wrs_pkg::LEN_W-1:0]     fin_len;
    logic [wrs_pkg::CHAR_W-1:0]    want_char;

    assign cfg.ready   = 1'b1;
    assign text.ready  = push_ready;
    assign accept      = text.valid && text.ready;
    assign cfg_regs    = cfg_reg;

    // clamped lengths
    assign flen = wrs_pkg::clamp_len(cfg_reg.find_len, wrs_pkg::LEN_W'(MAX_WORD));
    assign rlen = wrs_pkg::clamp_len(cfg_reg.replace_len, wrs_pkg::LEN_W'(MAX_WORD));

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.find_word    <= '0;
            cfg_reg.find_len     <= wrs_pkg::LEN_W'(1);
            cfg_reg.replace_word <= '0;
            cfg_reg.replace_len  <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                wrs_pkg::REG_FIND_WORD:    cfg_reg.find_word    <= cfg.data;
                wrs_pkg::REG_FIND_LEN:     cfg_reg.find_len     <= cfg.data[wrs_pkg::LEN_W-1:0];
                wrs_pkg::REG_REPLACE_WORD: cfg_reg.replace_word <= cfg.data;
                wrs_pkg::REG_REPLACE_LEN:  cfg_reg.replace_len  <= cfg.data[wrs_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // what a word end releases: replacement, held prefix or nothing
    always_comb
    begin
        fin_repl = 1'b0;
        fin_len  = '0;
        if (!pass_reg && held_reg != '0)
        begin
            if (held_reg == flen)
            begin
                fin_repl = 1'b1;
                fin_len  = rlen;
            end
            else
            begin
                fin_len = held_reg;
            end
        end
    end

    assign want_char = wrs_pkg::byte_of(cfg_reg.find_word,
                                        held_reg[wrs_pkg::BYTE_IDX_W-1:0]);

    // classify the accepted character
    always_comb
    begin
        push_valid          = 1'b0;
        push_data.use_repl  = 1'b0;
        push_data.pre_len   = '0;
        push_data.tail_char = text.char_in;
        push_data.tail_le   = 1'b0;
        held_next           = held_reg;
        pass_next           = pass_reg;
        if (accept)
        begin
            if (text.line_end)
            begin
                push_valid          = 1'b1;
                push_data.use_repl  = fin_repl;
                push_data.pre_len   = fin_len;
                push_data.tail_char = wrs_pkg::CH_NUL;
                push_data.tail_le   = 1'b1;
                held_next           = '0;
                pass_next           = 1'b0;
            end
            else if (wrs_pkg::is_sep(text.char_in))
            begin
                push_valid         = 1'b1;
                push_data.use_repl = fin_repl;
                push_data.pre_len  = fin_len;
                held_next          = '0;
                pass_next          = 1'b0;
            end
            else if (pass_reg)
            begin
                push_valid = 1'b1;
            end
            else if (held_reg < flen && text.char_in == want_char)
            begin
                held_next = held_reg + wrs_pkg::LEN_W'(1);
            end
            else
            begin
                // mismatch: release the held prefix, word passes from here on
                push_valid        = 1'b1;
                push_data.pre_len = held_reg;
                held_next         = '0;
                pass_next         = 1'b1;
            end
        end
    end

    // word state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
            pass_reg <= 1'b0;
        end
        else
        begin
            held_reg <= held_next;
            pass_reg <= pass_next;
        end
    end

endmodule

FILE: src/wrs_cmd_fifo.sv
// ----------------------------------------------------------------------------
// wrs_cmd_fifo: short request queue between front end and back end
// Small circular buffer; push when not full, pop when not empty.
// ----------------------------------------------------------------------------
module wrs_cmd_fifo #(
    parameter int DEPTH = wrs_pkg::FIFO_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    input  wrs_pkg::cmd_t push_data,
    output logic          push_ready,
    output logic          pop_valid,
    output wrs_pkg::cmd_t pop_data,
    input  logic          pop_ready
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    wrs_pkg::cmd_t     entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push, do_pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                              : wr_ptr_reg + PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                              : rd_ptr_reg + PTR_W'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

endmodule

FILE: src/wrs_back.sv
// ----------------------------------------------------------------------------
// wrs_back: result sequencer
// Expands one request into its prefix characters and a tail result, one result
// per cycle while the result channel is not stalled, through a registered output stage.
// ----------------------------------------------------------------------------
module wrs_back (
    input  logic          clk,
    input  logic          rst_n,
    input  wrs_pkg::cfg_t cfg_regs,
    input  logic          pop_valid,
    input  wrs_pkg::cmd_t pop_data,
    output logic          pop_ready,
    wrs_result_if.source  result
);

    wrs_pkg::cmd_t              cmd_reg;
    logic                       busy_reg;
    logic [wrs_pkg::LEN_W-1:0]  idx_reg;
    logic                       out_valid_reg;
    logic [wrs_pkg::CHAR_W-1:0] out_char_reg;
    logic                       out_le_reg;
    logic                       out_last_reg;
    logic                       can_emit, in_prefix, tail_emit;
    logic [wrs_pkg::WORD_W-1:0] src_word;
    logic [wrs_pkg::CHAR_W-1:0] pre_char;

    assign can_emit  = busy_reg && (!out_valid_reg || result.ready);
    assign in_prefix = idx_reg < cmd_reg.pre_len;
    assign tail_emit = can_emit && !in_prefix;
    assign pop_ready = !busy_reg || tail_emit;
    assign src_word  = cmd_reg.use_repl ? cfg_regs.replace_word : cfg_regs.find_word;
    assign pre_char  = wrs_pkg::byte_of(src_word, idx_reg[wrs_pkg::BYTE_IDX_W-1:0]);

    // request sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (pop_valid && pop_ready)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end
        else if (tail_emit)
        begin
            busy_reg <= 1'b0;
        end
        else if (can_emit)
        begin
            idx_reg <= idx_reg + wrs_pkg::LEN_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop_valid && pop_ready)
            cmd_reg <= pop_data;
    end

    // output stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (can_emit)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    // output stage payload
    always_ff @(posedge clk)
    begin
        if (can_emit)
        begin
            if (in_prefix)
            begin
                out_char_reg <= pre_char;
                out_le_reg   <= 1'b0;
                out_last_reg <= 1'b0;
            end
            else
            begin
                out_char_reg <= cmd_reg.tail_char;
                out_le_reg   <= cmd_reg.tail_le;
                out_last_reg <= 1'b1;
            end
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.char_out     = out_char_reg;
    assign result.line_end_out = out_le_reg;
    assign result.last         = out_last_reg;

endmodule

FILE: src/word_replace_stream_filter.sv
// An accepted item passes the queue entry, the back end request register and
// the output register before its first result appears. An item that extends
// a matching word gives nothing; one releasing held or replacement characters keeps
// the back end sequencer busy through them and the tail; input stalls once the 2-entry queue fills.
// Reset: rst_n clears word state, queue and output valid; registers take
// find_len 1, other registers 0.
// ----------------------------------------------------------------------------
// word_replace_stream_filter: whole-word find and replace on a text stream
// Front end tracks word matches, a short queue decouples it from the back
// end that writes out held characters, replacements and pass-through text.
// ----------------------------------------------------------------------------
module word_replace_stream_filter #(
    parameter int MAX_WORD   = wrs_pkg::MAX_WORD_DEF,
    parameter int FIFO_DEPTH = wrs_pkg::FIFO_DEPTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    wrs_text_if.sink     text,
    wrs_cfg_if.sink      cfg,
    wrs_result_if.source result
);

    logic          push_valid, push_ready;
    wrs_pkg::cmd_t push_data;
    logic          pop_valid, pop_ready;
    wrs_pkg::cmd_t pop_data;
    wrs_pkg::cfg_t cfg_regs;

    wrs_front #(
        .MAX_WORD (MAX_WORD)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .text       (text),
        .cfg        (cfg),
        .push_ready (push_ready),
        .push_valid (push_valid),
        .push_data  (push_data),
        .cfg_regs   (cfg_regs)
    );

    wrs_cmd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_data   (pop_data),
        .pop_ready  (pop_ready)
    );

    wrs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_regs  (cfg_regs),
        .pop_valid (pop_valid),
        .pop_data  (pop_data),
        .pop_ready (pop_ready),
        .result    (result)
    );

endmodule

FILE: src/wrs_checker.sv
// ----------------------------------------------------------------------------
// wrs_checker: port-level checks for the word replace stream filter
// Watches the result channel and flags malformed results.
// ----------------------------------------------------------------------------
module wrs_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       res_valid,
    input logic                       res_ready,
    input logic [wrs_pkg::CHAR_W-1:0] res_char,
    input logic                       res_le,
    input logic                       res_last
);

    // a stalled result holds its payload
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_char)
                                    && $stable(res_le) && $stable(res_last))
        else $error("result changed while stalled");

    // a line end is always the final result of its request
    a_le_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_le |-> res_last)
        else $error("line end result not marked last");

    // a line end carries no character
    a_le_nul: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_le |-> res_char == wrs_pkg::CH_NUL)
        else $error("line end result carries a character");

endmodule

bind word_replace_stream_filter wrs_checker u_wrs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .res_char  (result.char_out),
    .res_le    (result.line_end_out),
    .res_last  (result.last)
);

FILE: verif/word_replace_stream_filter_test.sv
// ----------------------------------------------------------------------------
// word_replace_stream_filter_test: self-checking bench for the word filter
// Streams text through the filter under several search and replacement
// settings and compares each output character with a cycle-free predictor.
// ----------------------------------------------------------------------------
module word_replace_stream_filter_test;

    localparam int WORD_CHARS = wrs_pkg::MAX_WORD_DEF;

    typedef struct packed {
        logic [wrs_pkg::CHAR_W-1:0] ch;
        logic                       le;
    } text_req_t;

    typedef struct packed {
        logic [wrs_pkg::CHAR_W-1:0] ch;
        logic                       le;
        logic                       last;
    } result_t;

    logic clk = 1'b0;
    logic rst_n;

    wrs_text_if   text_ch ();
    wrs_cfg_if    cfg_ch ();
    wrs_result_if res_ch ();

    word_replace_stream_filter DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text_ch),
        .cfg    (cfg_ch),
        .result (res_ch)
    );

    // predictor copy of registers and word state
    logic [wrs_pkg::WORD_W-1:0] cfg_find_word = '0;
    logic [wrs_pkg::LEN_W-1:0]  cfg_find_len  = 4'd1;
    logic [wrs_pkg::WORD_W-1:0] cfg_repl_word = '0;
    logic [wrs_pkg::LEN_W-1:0]  cfg_repl_len  = '0;
    int                         held_cnt      = 0;
    bit                         word_passing  = 1'b0;

    text_req_t text_backlog [$];
    result_t   expected_chars [$];
    text_req_t next_req;
    int        send_idle_pct;
    int        recv_idle_pct;
    int        hold_left  = 0;
    bit        hold_req   = 1'b0;
    int        mismatches = 0;

    logic [wrs_pkg::CHAR_W-1:0] sep_chars [9] = '{wrs_pkg::CH_UNDERSCORE, wrs_pkg::CH_SPACE,
                                                  wrs_pkg::CH_COMMA, wrs_pkg::CH_PERIOD,
                                                  wrs_pkg::CH_LESS, wrs_pkg::CH_GREATER,
                                                  wrs_pkg::CH_LPAREN, wrs_pkg::CH_RPAREN,
                                                  wrs_pkg::CH_QUOTE};

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit is_separator(input logic [wrs_pkg::CHAR_W-1:0] c);
        return c inside {wrs_pkg::CH_UNDERSCORE, wrs_pkg::CH_SPACE, wrs_pkg::CH_COMMA,
                         wrs_pkg::CH_PERIOD, wrs_pkg::CH_LESS, wrs_pkg::CH_GREATER,
                         wrs_pkg::CH_LPAREN, wrs_pkg::CH_RPAREN, wrs_pkg::CH_QUOTE};
    endfunction

    function automatic int eff_len(input logic [wrs_pkg::LEN_W-1:0] n);
        return (n > WORD_CHARS) ? WORD_CHARS : int'(n);
    endfunction

    function automatic result_t out_item(input logic [wrs_pkg::CHAR_W-1:0] ch,
                                         input logic le);
        result_t r;
        r.ch   = ch;
        r.le   = le;
        r.last = 1'b0;
        return r;
    endfunction

    // expected output characters for one accepted text request
    task automatic predict_output(input text_req_t req);
        result_t burst [$];
        int flen;
        int rlen;
        int i;
        flen = eff_len(cfg_find_len);
        rlen = eff_len(cfg_repl_len);
        if (req.le || is_separator(req.ch)) begin
            // word closes: replacement on exact match, held prefix otherwise
            if (!word_passing && held_cnt > 0) begin
                if (held_cnt == flen) begin
                    for (i = 0; i < rlen; i++)
                        burst.push_back(out_item(cfg_repl_word[8*i +: 8], 1'b0));
                end else begin
                    for (i = 0; i < held_cnt; i++)
                        burst.push_back(out_item(cfg_find_word[8*i +: 8], 1'b0));
                end
            end
            held_cnt     = 0;
            word_passing = 1'b0;
            burst.push_back(req.le ? out_item(wrs_pkg::CH_NUL, 1'b1) : out_item(req.ch, 1'b0));
        end else if (word_passing) begin
            burst.push_back(out_item(req.ch, 1'b0));
        end else if (held_cnt < flen && req.ch == cfg_find_word[8*held_cnt +: 8]) begin
            held_cnt++;
        end else begin
            // mismatch: release the held prefix, rest of word passes
            for (i = 0; i < held_cnt; i++)
                burst.push_back(out_item(cfg_find_word[8*i +: 8], 1'b0));
            burst.push_back(out_item(req.ch, 1'b0));
            held_cnt     = 0;
            word_passing = 1'b1;
        end
        if (burst.size() != 0)
            burst[burst.size()-1].last = 1'b1;
        foreach (burst[k])
            expected_chars.push_back(burst[k]);
    endtask

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_result();
        result_t want;
        if (expected_chars.size() == 0) begin
            report_mismatch($sformatf("unexpected result char %h le %b last %b",
                                      res_ch.char_out, res_ch.line_end_out, res_ch.last));
            return;
        end
        want = expected_chars.pop_front();
        if (res_ch.char_out !== want.ch)
            report_mismatch($sformatf("char_out %h, want %h", res_ch.char_out, want.ch));
        if (res_ch.line_end_out !== want.le)
            report_mismatch($sformatf("line_end_out %b, want %b",
                                      res_ch.line_end_out, want.le));
        if (res_ch.last !== want.last)
            report_mismatch($sformatf("last %b, want %b", res_ch.last, want.last));
    endtask

    // text driver: pops the backlog, predicts on each accepted request
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            text_ch.valid    <= 1'b0;
            text_ch.char_in  <= '0;
            text_ch.line_end <= 1'b0;
        end else begin
            if (text_ch.valid && text_ch.ready)
                predict_output(text_req_t'{ch: text_ch.char_in, le: text_ch.line_end});
            if (!text_ch.valid || text_ch.ready) begin
                if (text_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    next_req = text_backlog.pop_front();
                    text_ch.valid    <= 1'b1;
                    text_ch.char_in  <= next_req.ch;
                    text_ch.line_end <= next_req.le;
                end else begin
                    text_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor with random backpressure
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready)
                check_result();
            res_ch.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // long receiver hold-off counter
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_req)
            hold_left <= 300;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    task automatic write_reg(input logic [wrs_pkg::CFG_IDX_W-1:0] idx,
                             input logic [wrs_pkg::WORD_W-1:0] value);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            wrs_pkg::REG_FIND_WORD:    cfg_find_word = value;
            wrs_pkg::REG_FIND_LEN:     cfg_find_len  = value[wrs_pkg::LEN_W-1:0];
            wrs_pkg::REG_REPLACE_WORD: cfg_repl_word = value;
            wrs_pkg::REG_REPLACE_LEN:  cfg_repl_len  = value[wrs_pkg::LEN_W-1:0];
            default: ;
        endcase
    endtask

    // length registers get junk above their width, which must be dropped
    task automatic set_words(input logic [wrs_pkg::WORD_W-1:0] find,
                             input logic [wrs_pkg::LEN_W-1:0]  flen,
                             input logic [wrs_pkg::WORD_W-1:0] repl,
                             input logic [wrs_pkg::LEN_W-1:0]  rlen);
        logic [wrs_pkg::WORD_W-1:0] junk;
        junk = {$urandom, $urandom};
        junk[wrs_pkg::LEN_W-1:0] = flen;
        write_reg(wrs_pkg::REG_FIND_WORD, find);
        write_reg(wrs_pkg::REG_FIND_LEN, junk);
        write_reg(wrs_pkg::REG_REPLACE_WORD, repl);
        junk = {$urandom, $urandom};
        junk[wrs_pkg::LEN_W-1:0] = rlen;
        write_reg(wrs_pkg::REG_REPLACE_LEN, junk);
    endtask

    function automatic logic [wrs_pkg::CHAR_W-1:0] rand_letter();
        return wrs_pkg::CHAR_W'(8'h61 + $urandom_range(0, 3));
    endfunction

    // search word of small-alphabet letters, or of any non-separator bytes
    function automatic logic [wrs_pkg::WORD_W-1:0] rand_find(input bit letters);
        logic [wrs_pkg::WORD_W-1:0] w;
        logic [wrs_pkg::CHAR_W-1:0] c;
        int i;
        for (i = 0; i < WORD_CHARS; i++) begin
            if (letters)
                c = rand_letter();
            else
                do c = wrs_pkg::CHAR_W'($urandom_range(0, 255)); while (is_separator(c));
            w[8*i +: 8] = c;
        end
        return w;
    endfunction

    function automatic logic [wrs_pkg::WORD_W-1:0] pack_word(input string s);
        logic [wrs_pkg::WORD_W-1:0] w;
        int i;
        w = '0;
        for (i = 0; i < s.len(); i++)
            w[8*i +: 8] = s[i];
        return w;
    endfunction

    task automatic add_char(input logic [wrs_pkg::CHAR_W-1:0] c);
        text_backlog.push_back(text_req_t'{ch: c, le: 1'b0});
    endtask

    task automatic add_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            add_char(s[i]);
    endtask

    task automatic add_line_end();
        text_backlog.push_back(text_req_t'{ch: wrs_pkg::CHAR_W'($urandom_range(0, 255)),
                                           le: 1'b1});
    endtask

    // random text: mostly search-word shaped words, some noise
    task automatic queue_text(input int n_items);
        logic [wrs_pkg::CHAR_W-1:0] word [$];
        int flen;
        int kind;
        int wlen;
        int added;
        int i;
        flen  = eff_len(cfg_find_len);
        added = 0;
        while (added < n_items) begin
            word.delete();
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1, 2: begin
                    for (i = 0; i < flen; i++)
                        word.push_back(cfg_find_word[8*i +: 8]);
                end
                3: begin
                    wlen = (flen > 1) ? $urandom_range(1, flen - 1) : 1;
                    for (i = 0; i < wlen; i++)
                        word.push_back(cfg_find_word[8*i +: 8]);
                end
                4: begin
                    for (i = 0; i < flen; i++)
                        word.push_back(cfg_find_word[8*i +: 8]);
                    wlen = $urandom_range(1, 2);
                    for (i = 0; i < wlen; i++)
                        word.push_back(rand_letter());
                end
                5: begin
                    for (i = 0; i < flen; i++)
                        word.push_back(cfg_find_word[8*i +: 8]);
                    if (flen > 0)
                        word[$urandom_range(0, flen - 1)] = rand_letter();
                end
                6: begin
                    wlen = $urandom_range(1, 9);
                    for (i = 0; i < wlen; i++)
                        word.push_back(wrs_pkg::CHAR_W'($urandom_range(0, 255)));
                end
                default: begin
                    wlen = $urandom_range(1, 10);
                    for (i = 0; i < wlen; i++)
                        word.push_back(rand_letter());
                end
            endcase
            foreach (word[k])
                add_char(word[k]);
            added += word.size();
            // word terminator: separator, line end, or none (words run together)
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
                add_char(sep_chars[$urandom_range(0, 8)]);
                added++;
            end else if (kind < 9) begin
                add_line_end();
                added++;
            end
        end
    endtask

    task automatic wait_results();
        do @(negedge clk);
        while (text_backlog.size() != 0 || text_ch.valid || expected_chars.size() != 0);
    endtask

    // idle point: all results in, plus time for a held word to settle
    task automatic settle();
        wait_results();
        repeat (20) @(posedge clk);
    endtask

    initial begin
        logic [wrs_pkg::WORD_W-1:0] w;
        int n;
        rst_n         = 1'b0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.index  = '0;
        cfg_ch.data   = '0;
        send_idle_pct = 23;
        recv_idle_pct = 74;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: a zero byte is a word char that matches and is deleted
        add_char(wrs_pkg::CH_NUL);
        add_char(wrs_pkg::CH_SPACE);
        add_char(wrs_pkg::CH_NUL);
        add_char(wrs_pkg::CH_NUL);
        add_line_end();
        settle();

        // directed: match, longer word, partial prefix flush, separators
        set_words(pack_word("cat"), 4'd3, pack_word("DOG!!"), 4'd5);
        add_text("cat cats<ca");
        add_line_end();
        add_text("xcat\"cat");
        add_line_end();
        add_text("_,.>()");
        add_char(8'hFF);
        add_line_end();
        settle();

        // write to an index past the register list is dropped
        write_reg(wrs_pkg::CFG_IDX_W'($urandom_range(4, 255)), {$urandom, $urandom});

        // full length search and replacement; empty search word
        set_words(rand_find(1'b1), 4'd8, {$urandom, $urandom}, 4'd8);
        queue_text(40);
        add_line_end();
        settle();
        set_words(rand_find(1'b1), 4'd0, {$urandom, $urandom}, 4'd15);
        queue_text(40);
        add_line_end();
        settle();

        @(posedge clk);
        send_idle_pct <= 74;
        recv_idle_pct <= 23;

        // oversized search length, deleting replacement; sender waits mid-run
        set_words(rand_find(1'b0), 4'd15, {$urandom, $urandom}, 4'd0);
        queue_text(25);
        wait_results();
        queue_text(25);
        add_line_end();
        settle();

        // separator inside the search word: never matches
        w = rand_find(1'b1);
        w[15:8] = sep_chars[$urandom_range(0, 8)];
        set_words(w, 4'd4, {$urandom, $urandom}, 4'd3);
        queue_text(40);
        add_line_end();
        settle();

        @(posedge clk);
        send_idle_pct <= 0;
        recv_idle_pct <= 0;

        // one-char search, max replacement; receiver stalls long to fill the block
        set_words(rand_find(1'b1), 4'd1, {$urandom, $urandom}, 4'd8);
        queue_text(40);
        add_line_end();
        @(posedge clk);
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
        settle();

        for (n = 0; n < 3; n++) begin
            set_words(rand_find(1'b1), wrs_pkg::LEN_W'($urandom_range(2, 7)),
                      {$urandom, $urandom}, wrs_pkg::LEN_W'($urandom_range(0, 8)));
            queue_text(15);
            add_line_end();
            settle();
        end

        if (mismatches == 0 && expected_chars.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // run limit
    initial begin
        #3000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
